// ===== rtl/core/pbrf_pkg.sv =====
// Package for the polynomial bisection root finder.
// Shared constants and types; no dependencies.
package pbrf_pkg;

    localparam int unsigned NUM_COEF = 5;

    // configuration register indexes
    localparam logic [2:0] REG_COEF_X4   = 3'd0;
    localparam logic [2:0] REG_COEF_X3   = 3'd1;
    localparam logic [2:0] REG_COEF_X2   = 3'd2;
    localparam logic [2:0] REG_COEF_X1   = 3'd3;
    localparam logic [2:0] REG_COEF_X0   = 3'd4;
    localparam logic [2:0] REG_TOLERANCE = 3'd5;

    // request / response between sequencer and evaluator
    typedef struct packed {
        logic start;
    } eval_req_t;

    typedef struct packed {
        logic done;
        logic is_zero;
        logic is_neg;
    } eval_rsp_t;

endpackage

// ===== rtl/core/pbrf_mul.sv =====
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add.
// Depends on nothing; used by pbrf_eval.
module pbrf_mul #(
    parameter int unsigned AW = 64,
    parameter int unsigned BW = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic                 done,
    output logic signed [AW-1:0] product
);
    localparam int unsigned CW = $clog2(BW + 1);

    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [AW-1:0] a_reg;
    logic [BW-1:0]        b_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 run_reg;
    logic signed [AW-1:0] addend;

    // product truncated to AW bits; exact modulo 2^AW
    always_comb
    begin
        addend = b_reg[0] ? a_reg : '0;
        // top bit of b carries negative weight
        if (cnt_reg == CW'(BW - 1) && b_reg[0])
        begin
            acc_next = acc_reg - addend;
        end
        else
        begin
            acc_next = acc_reg + addend;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
            done    <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(BW - 1))
                begin
                    run_reg <= 1'b0;
                    done    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
        end
        else if (run_reg)
        begin
            acc_reg <= acc_next;
            a_reg   <= a_reg <<< 1;
            b_reg   <= b_reg >> 1;
        end
    end

    assign product = acc_reg;

endmodule

// ===== rtl/core/pbrf_eval.sv =====
// Horner evaluation of the quartic at x, exact at full width, on one
// shared bit-serial multiplier. Depends on pbrf_pkg and pbrf_mul.
module pbrf_eval #(
    parameter int unsigned VALUE_WIDTH   = 32,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pbrf_pkg::eval_req_t           req,
    input  logic signed [VALUE_WIDTH-1:0] x,
    input  logic signed [VALUE_WIDTH-1:0] coef [pbrf_pkg::NUM_COEF],
    output pbrf_pkg::eval_rsp_t           rsp
);
    // exact width of the scaled quartic plus guard bits
    localparam int unsigned AW = 5 * VALUE_WIDTH + 4 * FRACTION_BITS + 4;

    logic signed [AW-1:0] acc_reg;
    logic [2:0]           k_reg;
    logic                 busy_reg;
    logic                 mstart;
    logic                 mdone;
    logic signed [AW-1:0] prod;
    logic signed [AW-1:0] term;
    logic [2:0]           kidx;
    logic signed [AW-1:0] sum;

    pbrf_mul #(.AW(AW), .BW(VALUE_WIDTH)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mstart),
        .a       (acc_reg),
        .b       (x),
        .done    (mdone),
        .product (prod)
    );

    always_comb
    begin
        kidx = k_reg;
        term = AW'(coef[kidx]) <<< (FRACTION_BITS * k_reg);
        sum  = prod + term;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
            mstart   <= 1'b0;
            rsp      <= '0;
        end
        else
        begin
            mstart   <= 1'b0;
            rsp.done <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= 3'd1;
                mstart   <= 1'b1;
            end
            else if (busy_reg && mdone)
            begin
                if (k_reg == 3'(pbrf_pkg::NUM_COEF - 1))
                begin
                    busy_reg    <= 1'b0;
                    rsp.done    <= 1'b1;
                    rsp.is_zero <= (sum == '0);
                    rsp.is_neg  <= sum[AW-1];
                end
                else
                begin
                    k_reg  <= k_reg + 3'd1;
                    mstart <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= AW'(coef[0]);
        end
        else if (busy_reg && mdone)
        begin
            acc_reg <= sum;
        end
    end

endmodule

// ===== rtl/core/polynomial_bisection_root_finder.sv =====
// Top level of the polynomial bisection root finder.
// Depends on pbrf_pkg and pbrf_eval (which holds pbrf_mul).
//
// Usage: write coefficients (index 0..4, x^4 down to x^0) and the tolerance
// (index 5) through cfg_we/cfg_index/cfg_data while the block is idle.
// Pulse start with lower_bound/upper_bound while busy is low; the item is
// taken at that edge and busy rises. One result follows: root_estimate and
// exact_zero are shown for one cycle with done high, and busy falls then.
// Each polynomial evaluation runs Horner's rule on the shared bit-serial
// multiplier. An item costs one evaluation of f(upper), one per bisection
// step (at most about VALUE_WIDTH steps) and one final evaluation at the
// midpoint unless a step hits an exact zero; one item at a time.
// Reset clears coefficients to 0, tolerance to 1 and all control state.
// The receiver cannot stall: done is a one-cycle strobe.
module polynomial_bisection_root_finder #(
    parameter int unsigned VALUE_WIDTH   = 32,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [VALUE_WIDTH-1:0]        cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_WIDTH-1:0] lower_bound,
    input  logic signed [VALUE_WIDTH-1:0] upper_bound,
    output logic                          done,
    output logic signed [VALUE_WIDTH-1:0] root_estimate,
    output logic                          exact_zero
);
    localparam int unsigned W = VALUE_WIDTH;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EVHI  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_EVMID = 3'd3;
    localparam logic [2:0] ST_FINAL = 3'd4;

    logic signed [W-1:0] coef_reg [pbrf_pkg::NUM_COEF];
    logic [W-2:0]        tol_reg;
    logic [2:0]          state_reg;
    logic signed [W-1:0] lo_reg, hi_reg, mid_reg;
    logic [1:0]          su_reg; // sign of f(hi): 0 zero, 1 pos, 3 neg
    logic                busy_reg;

    pbrf_pkg::eval_req_t req;
    pbrf_pkg::eval_rsp_t rsp;
    logic signed [W-1:0] eval_x;
    logic [W-1:0]        width_diff;
    logic [W-2:0]        tol_eff;
    logic                keep_going;
    logic [1:0]          fm_code;
    logic signed [W:0]   avg_sum;
    logic signed [W-1:0] new_lo, new_hi;

    assign eval_x = (state_reg == ST_EVHI) ? hi_reg : mid_reg;

    pbrf_eval #(.VALUE_WIDTH(W), .FRACTION_BITS(FRACTION_BITS)) u_eval (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .x     (eval_x),
        .coef  (coef_reg),
        .rsp   (rsp)
    );

    always_comb
    begin
        tol_eff    = (tol_reg == '0) ? (W-1)'(1) : tol_reg;
        width_diff = W'(hi_reg - lo_reg);
        keep_going = (hi_reg > lo_reg) && (width_diff > W'(tol_eff));
        fm_code    = rsp.is_zero ? 2'd0 : (rsp.is_neg ? 2'd3 : 2'd1);
        // next bracket after a step
        if (su_reg != 2'd0 && fm_code != su_reg)
        begin
            new_lo = mid_reg;
            new_hi = hi_reg;
        end
        else
        begin
            new_lo = lo_reg;
            new_hi = mid_reg;
        end
        avg_sum = ({new_lo[W-1], new_lo} + {new_hi[W-1], new_hi}) >>> 1;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pbrf_pkg::NUM_COEF; i++)
            begin
                coef_reg[i] <= '0;
            end
            tol_reg <= (W-1)'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pbrf_pkg::REG_COEF_X4:   coef_reg[0] <= cfg_data;
                pbrf_pkg::REG_COEF_X3:   coef_reg[1] <= cfg_data;
                pbrf_pkg::REG_COEF_X2:   coef_reg[2] <= cfg_data;
                pbrf_pkg::REG_COEF_X1:   coef_reg[3] <= cfg_data;
                pbrf_pkg::REG_COEF_X0:   coef_reg[4] <= cfg_data;
                pbrf_pkg::REG_TOLERANCE: tol_reg     <= cfg_data[W-2:0];
                default: ;
            endcase
        end
    end

    // bisection sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            busy_reg      <= 1'b0;
            req           <= '0;
            done          <= 1'b0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
            su_reg        <= '0;
            root_estimate <= '0;
            exact_zero    <= 1'b0;
        end
        else
        begin
            req.start <= 1'b0;
            done      <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        busy_reg  <= 1'b1;
                        lo_reg    <= lower_bound;
                        hi_reg    <= upper_bound;
                        mid_reg   <= W'(({lower_bound[W-1], lower_bound}
                                       + {upper_bound[W-1], upper_bound}) >>> 1);
                        req.start <= 1'b1;
                        state_reg <= ST_EVHI;
                    end
                end
                ST_EVHI:
                begin
                    // hold until f(upper) is known
                    if (rsp.done)
                    begin
                        su_reg    <= fm_code;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    req.start <= 1'b1;
                    state_reg <= keep_going ? ST_EVMID : ST_FINAL;
                end
                ST_EVMID:
                begin
                    if (rsp.done)
                    begin
                        if (fm_code == 2'd0)
                        begin
                            // exact root: report it directly
                            root_estimate <= mid_reg;
                            exact_zero    <= 1'b1;
                            done          <= 1'b1;
                            busy_reg      <= 1'b0;
                            state_reg     <= ST_IDLE;
                        end
                        else
                        begin
                            lo_reg  <= new_lo;
                            hi_reg  <= new_hi;
                            mid_reg <= W'(avg_sum);
                            if (!(su_reg != 2'd0 && fm_code != su_reg))
                            begin
                                su_reg <= fm_code;
                            end
                            state_reg <= ST_CHECK;
                        end
                    end
                end
                ST_FINAL:
                begin
                    if (rsp.done)
                    begin
                        root_estimate <= mid_reg;
                        exact_zero    <= rsp.is_zero;
                        done          <= 1'b1;
                        busy_reg      <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy = busy_reg;

    // a result only while an item is in flight
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy_reg))
        else $error("result without item");
    // busy drops exactly with the result strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        ($past(busy_reg) && !busy_reg) |-> done)
        else $error("busy fell without result");
    // the bracket is never inverted after a bisection step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && $past(state_reg) == ST_EVMID) |-> (lo_reg <= hi_reg))
        else $error("bracket inverted");

endmodule
